FILE: rtl/qstd_pkg.sv
// ----------------------------------------------------------------------------
// qstd_pkg
// Shared types, codes and helper functions of the query string decoder.
// ----------------------------------------------------------------------------
package qstd_pkg;

  localparam logic [7:0] CH_AMP        = 8'h26;
  localparam logic [7:0] CH_EQ         = 8'h3D;
  localparam logic [7:0] CH_PCT        = 8'h25;
  localparam logic [7:0] CH_NUL        = 8'h00;
  localparam logic [7:0] PRINT_LO      = 8'd32;
  localparam logic [7:0] PRINT_HI      = 8'd126;
  localparam logic [7:0] STARTER_RESET = 8'h3F;

  localparam logic [1:0] KIND_KEY   = 2'd0;
  localparam logic [1:0] KIND_VALUE = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  localparam logic [1:0] PH_FIRST = 2'd0;
  localparam logic [1:0] PH_KEY   = 2'd1;
  localparam logic [1:0] PH_VALUE = 2'd2;

  localparam logic [1:0] ESC_NONE = 2'd0;
  localparam logic [1:0] ESC_PCT  = 2'd1;
  localparam logic [1:0] ESC_HEX  = 2'd2;

  localparam int unsigned MAX_RES = 3;
  localparam logic [1:0]  MAX_RES_N = 2'(MAX_RES);

  typedef struct packed {
    logic [1:0] phase;
    logic       key_nonempty;
    logic [1:0] escape_count;
    logic [7:0] held_hex_char;
    logic       end_owed;
  } state_t;

  typedef struct packed {
    logic [1:0]                 n;
    logic [MAX_RES-1:0][7:0]    b;
    logic [MAX_RES-1:0][1:0]    k;
  } res_list_t;

  function automatic logic hex_ok(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    return (c <= 8'h39) ? c[3:0] : (c[3:0] + 4'd9);
  endfunction

  function automatic res_list_t res_push(input res_list_t l, input logic [7:0] b,
                                         input logic [1:0] k, input logic on);
    res_list_t r;
    r = l;
    if (on && (l.n < MAX_RES_N)) begin
      r.b[l.n] = b;
      r.k[l.n] = k;
      r.n      = l.n + 2'd1;
    end
    return r;
  endfunction

  function automatic res_list_t esc_flush(input res_list_t l, input logic [1:0] ec,
                                          input logic [7:0] hh, input logic [1:0] k,
                                          input logic on);
    res_list_t r;
    r = l;
    if (ec != ESC_NONE) r = res_push(r, CH_PCT, k, on);
    if (ec == ESC_HEX)  r = res_push(r, hh, k, on);
    return r;
  endfunction

endpackage

FILE: rtl/qstd_decode.sv
// ----------------------------------------------------------------------------
// qstd_decode
// Tokenizer and percent decoder for one byte: next state and up to three
// tagged results.
// ----------------------------------------------------------------------------
module qstd_decode (
  input  logic [7:0]          in_byte,
  input  logic                end_of_query,
  input  logic [7:0]          starter_char,
  input  qstd_pkg::state_t    state,
  output qstd_pkg::state_t    state_next,
  output qstd_pkg::res_list_t res
);
  import qstd_pkg::*;

  always_comb begin
    res_list_t  l;
    logic [1:0] ph;
    logic       kn;
    logic [1:0] ec;
    logic [7:0] hh;
    logic       eo;
    logic       in_value;
    logic [1:0] k;
    logic       gate;
    logic [7:0] v;

    l  = '0;
    ph = state.phase;
    kn = state.key_nonempty;
    ec = state.escape_count;
    hh = state.held_hex_char;
    eo = state.end_owed;
    v  = {hex_val(hh), hex_val(in_byte)};

    in_value = (ph == PH_VALUE);
    k        = in_value ? KIND_VALUE : KIND_KEY;
    gate     = in_value ? kn : 1'b1;

    if (eo) begin
      l  = res_push(l, 8'h00, KIND_END, 1'b1);
      eo = 1'b0;
    end

    if (ph == PH_FIRST && starter_char != 8'h00 && in_byte == starter_char) begin
      // skipped
    end else if (ph != PH_VALUE && in_byte == CH_EQ) begin
      l  = esc_flush(l, ec, hh, KIND_KEY, 1'b1);
      ec = ESC_NONE;
      hh = 8'h00;
      ph = PH_VALUE;
    end else if (in_byte == CH_AMP || in_byte == CH_NUL) begin
      l  = esc_flush(l, ec, hh, k, gate);
      ec = ESC_NONE;
      hh = 8'h00;
      if (kn) l = res_push(l, 8'h00, KIND_END, 1'b1);
      kn = 1'b0;
      ph = PH_KEY;
    end else begin
      if (in_byte == CH_PCT) begin
        l  = esc_flush(l, ec, hh, k, gate);
        ec = ESC_PCT;
        hh = 8'h00;
      end else if (ec == ESC_NONE) begin
        l = res_push(l, in_byte, k, gate);
      end else if (!hex_ok(in_byte)) begin
        l  = esc_flush(l, ec, hh, k, gate);
        l  = res_push(l, in_byte, k, gate);
        ec = ESC_NONE;
        hh = 8'h00;
      end else if (ec == ESC_PCT) begin
        hh = in_byte;
        ec = ESC_HEX;
      end else begin
        if (v >= PRINT_LO && v <= PRINT_HI) begin
          l = res_push(l, v, k, gate);
        end else if (v > PRINT_HI) begin
          l = res_push(l, CH_PCT, k, gate);
          l = res_push(l, hh, k, gate);
          l = res_push(l, in_byte, k, gate);
        end
        ec = ESC_NONE;
        hh = 8'h00;
      end
      if (!in_value) kn = 1'b1;
    end

    if (end_of_query) begin
      in_value = (ph == PH_VALUE);
      k        = in_value ? KIND_VALUE : KIND_KEY;
      gate     = in_value ? kn : 1'b1;
      l        = esc_flush(l, ec, hh, k, gate);
      if (kn) begin
        if (l.n < MAX_RES_N) l = res_push(l, 8'h00, KIND_END, 1'b1);
        else eo = 1'b1;
      end
      ph = PH_FIRST;
      kn = 1'b0;
      ec = ESC_NONE;
      hh = 8'h00;
    end

    res                      = l;
    state_next.phase         = ph;
    state_next.key_nonempty  = kn;
    state_next.escape_count  = ec;
    state_next.held_hex_char = hh;
    state_next.end_owed      = eo;
  end

endmodule

FILE: rtl/qstd_outbuf.sv
// ----------------------------------------------------------------------------
// qstd_outbuf
// Result register: holds the results of one byte and hands them out one
// request per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module qstd_outbuf (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  qstd_pkg::res_list_t res,
  output logic                can_load,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_byte,
  output logic [1:0]          kind,
  output logic                last_of_run
);
  import qstd_pkg::*;

  logic [1:0]              count;
  logic [1:0]              rd;
  logic [MAX_RES-1:0][7:0] b;
  logic [MAX_RES-1:0][1:0] k;
  logic                    take;

  assign out_valid   = (count != 2'd0);
  assign take        = out_valid && out_ready;
  assign can_load    = (count == 2'd0) || (count == 2'd1 && out_ready);
  assign out_byte    = b[rd];
  assign kind        = k[rd];
  assign last_of_run = (count == 2'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
      rd    <= 2'd0;
    end else if (load) begin
      count <= res.n;
      rd    <= 2'd0;
    end else if (take) begin
      count <= count - 2'd1;
      rd    <= rd + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      b <= res.b;
      k <= res.k;
    end
  end

endmodule

FILE: rtl/query_string_tokenizer_decoder_unit.sv
// ----------------------------------------------------------------------------
// query_string_tokenizer_decoder_unit
// URL query string tokenizer with percent decoding, one raw byte a request.
// ----------------------------------------------------------------------------
// input channel: in_valid/in_ready carry in_byte and end_of_query
// output channel: out_valid/out_ready carry out_byte, kind, last_of_run
// kind 0 key byte, 1 value byte, 2 pair end; last_of_run marks the final
//   result caused by one input byte, a byte may cause zero to three results
// config: cfg_wr_en writes cfg_wr_data into the starter byte; the user must
//   write it only while idle, the block does not enforce this
// path: a taken byte waits in the input register until the result register
//   can load, then is decoded into it and its results are handed out
// throughput: one byte per cycle while out_ready is high and each byte
//   gives at most one result; more hold the result register until drained
// stall: when out_ready is low the result register holds, the input
//   register fills and then in_ready drops; nothing is lost
// reset: rst clears the tokenizer state, empties both registers and sets
//   the starter byte to '?'
// ----------------------------------------------------------------------------
module query_string_tokenizer_decoder_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       end_of_query,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [1:0] kind,
  output logic       last_of_run
);
  import qstd_pkg::*;

  logic       starter_char;
  logic [7:0] starter;
  logic       s_valid;
  logic [7:0] s_byte;
  logic       s_eoq;
  logic       can_load;
  logic       advance;
  state_t     state;
  state_t     state_next;
  res_list_t  res;

  assign starter_char = (starter != 8'h00);
  assign in_ready     = !s_valid || can_load;
  assign advance      = s_valid && can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      starter <= STARTER_RESET;
    end else if (cfg_wr_en) begin
      starter <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s_valid <= 1'b1;
    end else if (advance) begin
      s_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s_byte <= in_byte;
      s_eoq  <= end_of_query;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  qstd_decode u_decode (
    .in_byte      (s_byte),
    .end_of_query (s_eoq),
    .starter_char (starter_char ? starter : 8'h00),
    .state        (state),
    .state_next   (state_next),
    .res          (res)
  );

  qstd_outbuf u_outbuf (
    .clk         (clk),
    .rst         (rst),
    .load        (advance),
    .res         (res),
    .can_load    (can_load),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .kind        (kind),
    .last_of_run (last_of_run)
  );

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (s_valid && out_valid))
    else $error("input stalled without a pending item");

  a_end_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_END) |-> (out_byte == 8'h00))
    else $error("pair end carries a nonzero byte");

  a_eoq_resets: assert property (@(posedge clk) disable iff (rst)
    (advance && s_eoq) |=> (state.phase == PH_FIRST && !state.key_nonempty &&
                            state.escape_count == ESC_NONE))
    else $error("end of query did not restart the tokenizer");

  a_escape_code: assert property (@(posedge clk) disable iff (rst)
    state.escape_count == ESC_NONE || state.escape_count == ESC_PCT ||
    state.escape_count == ESC_HEX)
    else $error("bad escape count");

  a_drain_empty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last_of_run && !advance) |=> !out_valid)
    else $error("result register not empty after last result");

endmodule
